/* hw/rtl/slcan_line_to_can_frame_defines.svh */
// Assertion helpers for the RTL; slc_back includes this file.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SLCAN_LINE_TO_CAN_FRAME_DEFINES_SVH
`define SLCAN_LINE_TO_CAN_FRAME_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define SLC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("slcan assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define SLC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slcan assertion failed");

`endif

/* hw/rtl/slc_pkg.sv */
package slc_pkg;

  // Default line-length parameter: a line may hold up to MaxLine - 2 characters before its terminator.
  localparam int MaxLineDefault = 255;

  // Position of the DLC digit in the short and the extended form.
  localparam int DlcPosStd = 4;
  localparam int DlcPosExt = 9;

  // Data nibble slots: eight bytes of two hex digits.
  localparam int DataNibbles = 16;

  // Depth of the queue between the front and the back part.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadCmd  = 3'd1;
  localparam logic [2:0] StBadDlc  = 3'd2;
  localparam logic [2:0] StBadData = 3'd3;
  localparam logic [2:0] StTooLong = 3'd4;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic       is_term;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       cmd_std;
    logic       cmd_ext;
    logic       dlc_ok;
    logic [3:0] dlc_val;
  } char_class_t;

endpackage

/* hw/rtl/slc_char_if.sv */
interface slc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_char;

  modport source (output valid, output line_char, input ready);
  modport sink (input valid, input line_char, output ready);
endinterface

/* hw/rtl/slc_frame_if.sv */
interface slc_frame_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [31:0] frame_id;
  logic [3:0]  frame_dlc;
  logic [63:0] frame_data;

  modport source (output valid, output frame_status, output frame_id, output frame_dlc,
                  output frame_data, input ready);
  modport sink (input valid, input frame_status, input frame_id, input frame_dlc,
                input frame_data, output ready);
endinterface

/* hw/rtl/slc_front.sv */
module slc_front (
  slc_char_if.sink           char_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output slc_pkg::char_class_t push_entry_o
);

  slc_pkg::char_class_t cls;

  // Decode one character into the flags the line parser works on.
  always_comb begin
    cls = '0;
    cls.is_term = (char_i.line_char == slc_pkg::CharCr) ||
                  (char_i.line_char == slc_pkg::CharLf);
    if (char_i.line_char inside {[8'h30:8'h39]}) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = char_i.line_char[3:0];
    end else if ((char_i.line_char inside {[8'h41:8'h46]}) ||
                 (char_i.line_char inside {[8'h61:8'h66]})) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = char_i.line_char[3:0] + 4'd9;
    end
    cls.cmd_std = char_i.line_char inside {8'h74, 8'h72};
    cls.cmd_ext = char_i.line_char inside {8'h54, 8'h52};
    if (char_i.line_char inside {[8'h30:8'h38]}) begin
      cls.dlc_ok  = 1'b1;
      cls.dlc_val = char_i.line_char[3:0];
    end
  end

  assign push_valid_o = char_i.valid;
  assign push_entry_o = cls;
  assign char_i.ready = push_ready_i;

endmodule

/* hw/rtl/slc_queue.sv */
module slc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  slc_pkg::char_class_t push_entry_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output slc_pkg::char_class_t pop_entry_o
);

  slc_pkg::char_class_t mem_q [slc_pkg::QueueDepth];

  logic [slc_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [slc_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [slc_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign push_ready_o = (cnt_q != slc_pkg::QueueCntW'(slc_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* hw/rtl/slc_back.sv */
`include "slcan_line_to_can_frame_defines.svh"

module slc_back #(
  parameter int MaxLine = slc_pkg::MaxLineDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  slc_pkg::char_class_t pop_entry_i,
  slc_frame_if.source          frame_o
);

  localparam int PosW = $clog2(MaxLine);
  localparam logic [PosW-1:0] LastPos = PosW'(MaxLine - 2);
  localparam logic [PosW-1:0] DlcStd  = PosW'(slc_pkg::DlcPosStd);
  localparam logic [PosW-1:0] DlcExt  = PosW'(slc_pkg::DlcPosExt);
  localparam logic [PosW-1:0] NibLim  = PosW'(slc_pkg::DataNibbles);

  logic [PosW-1:0] pos_q, pos_d;
  logic            ext_q, ext_d;
  logic [31:0]     id_q, id_d;
  logic            ended_q, ended_d;
  logic [3:0]      len_q, len_d;
  logic [63:0]     data_q, data_d;
  logic [2:0]      err_q, err_d;
  logic            discard_q, discard_d;

  logic            out_valid_q, out_valid_d;
  logic [2:0]      out_status_q, out_status_d;
  logic [31:0]     out_id_q, out_id_d;
  logic [3:0]      out_dlc_q, out_dlc_d;
  logic [63:0]     out_data_q, out_data_d;

  logic            pop;
  logic [PosW-1:0] dlc_pos;
  logic [PosW-1:0] k;
  logic [PosW-1:0] need;
  logic [3:0]      nib;
  logic [2:0]      status;
  logic            payload_zero;

  assign pop_ready_o = !pop_entry_i.is_term || !out_valid_q || frame_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign dlc_pos     = ext_q ? DlcExt : DlcStd;
  assign k           = pos_q - dlc_pos - 1'b1;
  assign need        = PosW'({len_q, 1'b0});
  assign nib         = {k[3:1], ~k[0]};

  always_comb begin
    if (discard_q) begin
      status = slc_pkg::StTooLong;
    end else if (err_q != slc_pkg::StOk) begin
      status = err_q;
    end else if (pos_q == '0) begin
      status = slc_pkg::StBadCmd;
    end else if (pos_q <= dlc_pos) begin
      status = slc_pkg::StBadDlc;
    end else if (k < need) begin
      status = slc_pkg::StBadData;
    end else begin
      status = slc_pkg::StOk;
    end
  end

  always_comb begin
    pos_d        = pos_q;
    ext_d        = ext_q;
    id_d         = id_q;
    ended_d      = ended_q;
    len_d        = len_q;
    data_d       = data_q;
    err_d        = err_q;
    discard_d    = discard_q;
    out_valid_d  = out_valid_q && !frame_o.ready;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_dlc_d    = out_dlc_q;
    out_data_d   = out_data_q;

    if (pop) begin
      if (pop_entry_i.is_term) begin
        out_valid_d  = 1'b1;
        out_status_d = status;
        out_id_d     = (status == slc_pkg::StOk) ? id_q : '0;
        out_dlc_d    = (status == slc_pkg::StOk) ? len_q : '0;
        out_data_d   = (status == slc_pkg::StOk) ? data_q : '0;
        pos_d        = '0;
        ext_d        = 1'b0;
        id_d         = '0;
        ended_d      = 1'b0;
        len_d        = '0;
        data_d       = '0;
        err_d        = slc_pkg::StOk;
        discard_d    = 1'b0;
      end else if (!discard_q) begin
        if (pos_q >= LastPos) begin
          discard_d = 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
          if (pos_q == '0) begin
            if (pop_entry_i.cmd_std) begin
              ext_d = 1'b0;
            end else if (pop_entry_i.cmd_ext) begin
              ext_d = 1'b1;
            end else begin
              err_d = slc_pkg::StBadCmd;
            end
          end else if (err_q == slc_pkg::StOk) begin
            if (pos_q < dlc_pos) begin
              if (!ended_q) begin
                if (pop_entry_i.hex_ok) begin
                  id_d = {id_q[27:0], pop_entry_i.hex_val};
                end else begin
                  ended_d = 1'b1;
                end
              end
            end else if (pos_q == dlc_pos) begin
              if (pop_entry_i.dlc_ok) begin
                len_d = pop_entry_i.dlc_val;
              end else begin
                err_d = slc_pkg::StBadDlc;
              end
            end else if ((k < need) && (k < NibLim)) begin
              if (pop_entry_i.hex_ok) begin
                data_d[nib*4 +: 4] = pop_entry_i.hex_val;
              end else begin
                err_d = slc_pkg::StBadData;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ext_q       <= 1'b0;
      id_q        <= '0;
      ended_q     <= 1'b0;
      len_q       <= '0;
      data_q      <= '0;
      err_q       <= slc_pkg::StOk;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ext_q       <= ext_d;
      id_q        <= id_d;
      ended_q     <= ended_d;
      len_q       <= len_d;
      data_q      <= data_d;
      err_q       <= err_d;
      discard_q   <= discard_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_dlc_q    <= out_dlc_d;
    out_data_q   <= out_data_d;
  end

  assign frame_o.valid        = out_valid_q;
  assign frame_o.frame_status = out_status_q;
  assign frame_o.frame_id     = out_id_q;
  assign frame_o.frame_dlc    = out_dlc_q;
  assign frame_o.frame_data   = out_data_q;

  assign payload_zero = (out_id_q == '0) && (out_dlc_q == '0) && (out_data_q == '0);

  // A failed line carries no frame content.
  `SLC_ASSERT_IMPL(a_err_zero_payload, out_valid_q && (out_status_q != slc_pkg::StOk), payload_zero)
  // While discarding, the position counter sits at its last value.
  `SLC_ASSERT_IMPL(a_discard_pos, discard_q, pos_q == LastPos)
  // A held result is never overwritten by the next terminator.
  `SLC_ASSERT_IMPL(a_no_overwrite, out_valid_q && !frame_o.ready, !(pop && pop_entry_i.is_term))

endmodule

/* hw/rtl/slcan_line_to_can_frame.sv */
// Serial-line CAN text parser: one ASCII character enters per transaction and
// every CR or LF produces one frame transaction with a status, the identifier,
// the DLC and up to eight data bytes (byte i in bits 8i+7..8i, unused bytes and
// the identifier, DLC and data of a failed line zero). The block sustains one
// character per clock cycle while the queue is not full; a character is decoded
// in the cycle it is accepted, queued, and folded into the line state by the
// back part. A terminator is written into a queue entry and then popped by the
// back part, which loads the finished frame into its output register. A result
// that is not yet taken holds back only the next terminator; the characters
// before it keep flowing, while the ones behind it wait once both queue entries
// are full.
module slcan_line_to_can_frame #(
  parameter int MaxLine = slc_pkg::MaxLineDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slc_char_if.sink    in_i,
  slc_frame_if.source out_o
);

  // Classified characters travel from the decoder through the queue.
  logic                 push_valid;
  logic                 push_ready;
  slc_pkg::char_class_t push_entry;
  logic                 pop_valid;
  logic                 pop_ready;
  slc_pkg::char_class_t pop_entry;

  // The front decodes each character into hex, command, DLC and terminator flags.
  slc_front u_front (
    .char_i       (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // The queue decouples input acceptance from the frame output stall.
  slc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // The back part tracks the line position, accumulates the fields and holds
  // the finished frame in its output register.
  slc_back #(
    .MaxLine (MaxLine)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .frame_o     (out_o)
  );

endmodule
